// ===== hw/rtl/rmth_pkg.sv =====
`timescale 1ns / 1ps
package rmth_pkg;

  localparam int unsigned CapacityDef    = 1024;
  localparam int unsigned SampleWidthDef = 32;

  // operation applied to every cell of one sorted chain in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_SWAP
  } chain_op_e;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_e;

endpackage

// ===== hw/rtl/rmth_cell.sv =====
`timescale 1ns / 1ps
module rmth_cell #(
  parameter int unsigned W         = rmth_pkg::SampleWidthDef,
  parameter bit          MAX_FIRST = 1'b1
) (
  input  logic                clk_i,
  input  rmth_pkg::chain_op_e op_i,
  input  logic signed [W-1:0] x_i,
  input  logic                first_i,
  input  logic                occ_i,
  input  logic                prev_occ_i,
  input  logic                prev_keep_i,
  input  logic signed [W-1:0] prev_val_i,
  input  logic                next_keep_i,
  input  logic signed [W-1:0] next_val_i,
  output logic signed [W-1:0] val_o,
  output logic                keep_o
);

  logic signed [W-1:0] val_q, val_d;
  logic                ahead;

  // a held value stays ahead of the new one when it is not worse in chain order
  assign ahead  = MAX_FIRST ? (val_q >= x_i) : (val_q <= x_i);
  assign keep_o = occ_i && ahead;
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    case (op_i)
      rmth_pkg::OP_PUSH: begin
        // shift down below the insertion point, take the new value at it
        if (prev_occ_i && !keep_o) begin
          val_d = prev_keep_i ? x_i : prev_val_i;
        end
      end
      rmth_pkg::OP_SWAP: begin
        // drop the top, shift up, and insert the new value in order
        if (occ_i) begin
          if (next_keep_i) begin
            val_d = next_val_i;
          end else if (first_i || keep_o) begin
            val_d = x_i;
          end
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== hw/rtl/rmth_chain.sv =====
`timescale 1ns / 1ps
module rmth_chain #(
  parameter int unsigned DEPTH     = rmth_pkg::CapacityDef / 2,
  parameter int unsigned W         = rmth_pkg::SampleWidthDef,
  parameter bit          MAX_FIRST = 1'b1,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmth_pkg::chain_op_e op_i,
  input  logic signed [W-1:0] x_i,
  output logic signed [W-1:0] top_o,
  output logic [CntW-1:0]     count_o
);

  logic [CntW-1:0]     count_q, count_d;
  logic signed [W-1:0] val  [DEPTH];
  logic                keep [DEPTH];
  logic                occ  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                p_occ, p_keep, n_keep;
    logic signed [W-1:0] p_val, n_val;

    assign occ[i] = count_q > CntW'(i);

    if (i == 0) begin : g_head
      assign p_occ  = 1'b1;
      assign p_keep = 1'b1;
      assign p_val  = x_i;
    end else begin : g_body
      assign p_occ  = occ[i-1];
      assign p_keep = keep[i-1];
      assign p_val  = val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_keep = 1'b0;
      assign n_val  = x_i;
    end else begin : g_link
      assign n_keep = keep[i+1];
      assign n_val  = val[i+1];
    end

    rmth_cell #(
      .W         (W),
      .MAX_FIRST (MAX_FIRST)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op_i),
      .x_i         (x_i),
      .first_i     (i == 0),
      .occ_i       (occ[i]),
      .prev_occ_i  (p_occ),
      .prev_keep_i (p_keep),
      .prev_val_i  (p_val),
      .next_keep_i (n_keep),
      .next_val_i  (n_val),
      .val_o       (val[i]),
      .keep_o      (keep[i])
    );
  end

  assign count_d = (op_i == rmth_pkg::OP_PUSH) ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = val[0];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/running_median_two_heaps.sv =====
`timescale 1ns / 1ps
// The cell chains update at the input transfer edge; the median of the two chain tops is
// registered when the FSM leaves S_CALC, which waits while an earlier result is still
// unaccepted on the output. A new sample is refused until the last one's result is loaded
// into the output register.
// A new input is taken while a finished result still waits on the output.
// Reset clears the FSM, output valid and both half counts; cell contents are not cleared.
module running_median_two_heaps #(
  parameter int unsigned CAPACITY     = rmth_pkg::CapacityDef,
  parameter int unsigned SAMPLE_WIDTH = rmth_pkg::SampleWidthDef,
  localparam int unsigned LoDepth     = (CAPACITY + 1) / 2,
  localparam int unsigned UpDepth     = CAPACITY / 2,
  localparam int unsigned CntW        = $clog2(CAPACITY + 1),
  localparam int unsigned LoCntW      = $clog2(LoDepth + 1),
  localparam int unsigned UpCntW      = $clog2(UpDepth + 1),
  localparam int unsigned MedW        = SAMPLE_WIDTH + 1,
  localparam int unsigned InW         = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutW        = ((MedW + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,   // median_times_two, then sample_count
  output logic            m_axis_tuser    // dropped
);

  rmth_pkg::state_e    state_q, state_d;
  rmth_pkg::chain_op_e lo_op, up_op;
  logic signed [SAMPLE_WIDTH-1:0] x, lo_x, up_x, lo_top, up_top;
  logic [LoCntW-1:0]   lo_cnt;
  logic [UpCntW-1:0]   up_cnt;
  logic [CntW-1:0]     total;
  logic                accept, full, even;
  logic                drop_q, drop_d;
  logic                out_valid_q, out_valid_d, load;
  logic signed [MedW-1:0] med_q, med_d;
  logic [CntW-1:0]     cnt_q;
  logic                out_drop_q;

  assign x     = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign total = CntW'(lo_cnt) + CntW'(up_cnt);
  assign full  = total == CntW'(CAPACITY);
  assign even  = CntW'(lo_cnt) == CntW'(up_cnt);

  rmth_chain #(
    .DEPTH     (LoDepth),
    .W         (SAMPLE_WIDTH),
    .MAX_FIRST (1'b1)
  ) u_lower (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (lo_op),
    .x_i     (lo_x),
    .top_o   (lo_top),
    .count_o (lo_cnt)
  );

  rmth_chain #(
    .DEPTH     (UpDepth),
    .W         (SAMPLE_WIDTH),
    .MAX_FIRST (1'b0)
  ) u_upper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (up_op),
    .x_i     (up_x),
    .top_o   (up_top),
    .count_o (up_cnt)
  );

  assign s_axis_tready = state_q == rmth_pkg::S_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    lo_op   = rmth_pkg::OP_HOLD;
    up_op   = rmth_pkg::OP_HOLD;
    lo_x    = x;
    up_x    = x;
    load    = 1'b0;
    case (state_q)
      rmth_pkg::S_IDLE: begin
        if (accept) begin
          state_d = rmth_pkg::S_CALC;
          drop_d  = full;
          if (!full) begin
            if (even) begin
              // sample above the upper top: move that top down, sample takes its place
              if (up_cnt != '0 && x > up_top) begin
                up_op = rmth_pkg::OP_SWAP;
                lo_op = rmth_pkg::OP_PUSH;
                lo_x  = up_top;
              end else begin
                lo_op = rmth_pkg::OP_PUSH;
              end
            end else begin
              if (lo_cnt != '0 && lo_top > x) begin
                lo_op = rmth_pkg::OP_SWAP;
                up_op = rmth_pkg::OP_PUSH;
                up_x  = lo_top;
              end else begin
                up_op = rmth_pkg::OP_PUSH;
              end
            end
          end
        end
      end
      rmth_pkg::S_CALC: begin
        if (!out_valid_q || m_axis_tready) begin
          load    = 1'b1;
          state_d = rmth_pkg::S_IDLE;
        end
      end
      default: state_d = rmth_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (lo_cnt == '0) begin
      med_d = '0;
    end else if (total[0] || up_cnt == '0) begin
      med_d = {lo_top, 1'b0};
    end else begin
      med_d = MedW'(lo_top) + MedW'(up_top);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmth_pkg::S_IDLE;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      med_q      <= med_d;
      cnt_q      <= total;
      out_drop_q <= drop_q;
    end
  end

  always_comb begin
    m_axis_tdata                       = '0;
    m_axis_tdata[MedW-1:0]             = med_q;
    m_axis_tdata[MedW+CntW-1:MedW]     = cnt_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_drop_q;

endmodule

// ===== tb/sv/running_median_two_heaps_tb.sv =====
`timescale 1ns / 1ps
module running_median_two_heaps_tb;

  localparam int unsigned Capacity = rmth_pkg::CapacityDef;
  localparam int unsigned PhaseLen = 360;
  localparam int unsigned DropTail = 60;

  typedef struct packed {
    logic [32:0] med2;
    logic [10:0] count;
    logic        dropped;
  } median_res_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        known;
    median_res_t res;
  } opening_row_t;

  localparam int NumOpening = 18;

  // extremes first (median readable by hand), then ties with the tops and exchanges
  opening_row_t opening_rows [NumOpening] = '{
    '{32'h8000_0000, 1'b1, '{33'h1_0000_0000, 11'd1, 1'b0}},
    '{32'h7FFF_FFFF, 1'b1, '{33'h1_FFFF_FFFF, 11'd2, 1'b0}},
    '{32'h0000_0000, 1'b1, '{33'h0_0000_0000, 11'd3, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h0000_0000, 1'b0, '0},
    '{32'h0000_0000, 1'b0, '0},
    '{32'h0000_0005, 1'b0, '0},
    '{32'hFFFF_FFFB, 1'b0, '0},
    '{32'h0000_0005, 1'b0, '0},
    '{32'h0000_0001, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h7FFF_FFFE, 1'b0, '0},
    '{32'h8000_0001, 1'b0, '0},
    '{32'h0000_0005, 1'b0, '0},
    '{32'h0000_0003, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  // lower half ascending, upper half descending: both tops sit at the back
  longint      lower_q[$];
  longint      upper_q[$];
  median_res_t expected_medians[$];

  int unsigned tx_idle_pct = 7;
  int unsigned rx_idle_pct = 80;
  int unsigned samples_sent = 0;
  int unsigned drops_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;

  running_median_two_heaps uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void lower_put(input longint x);
    int i;
    i = lower_q.size();
    while (i > 0 && lower_q[i-1] > x) i--;
    lower_q.insert(i, x);
  endfunction

  function automatic void upper_put(input longint x);
    int i;
    i = upper_q.size();
    while (i > 0 && upper_q[i-1] < x) i--;
    upper_q.insert(i, x);
  endfunction

  function automatic median_res_t median_advance(input logic signed [31:0] smp);
    median_res_t r;
    longint      x;
    longint      t;
    longint      med;
    int unsigned total;
    x = smp;
    r.dropped = (lower_q.size() + upper_q.size() >= Capacity);
    if (!r.dropped) begin
      if (lower_q.size() == upper_q.size()) begin
        // sample above the upper top: move that top down, sample goes up
        if (upper_q.size() != 0 && x > upper_q[$]) begin
          t = upper_q.pop_back();
          lower_put(t);
          upper_put(x);
        end else begin
          lower_put(x);
        end
      end else begin
        if (lower_q.size() != 0 && lower_q[$] > x) begin
          t = lower_q.pop_back();
          upper_put(t);
          lower_put(x);
        end else begin
          upper_put(x);
        end
      end
    end
    total = lower_q.size() + upper_q.size();
    med = 0;
    if (lower_q.size() != 0) begin
      if (total[0] || upper_q.size() == 0) med = 2 * lower_q[$];
      else med = lower_q[$] + upper_q[$];
    end
    r.med2  = med[32:0];
    r.count = total[10:0];
    return r;
  endfunction

  // handshakes are evaluated at the falling edge, where every signal is settled
  task automatic send_sample(input logic [31:0] smp, input logic known, input median_res_t typed);
    median_res_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(negedge clk_i); while (!s_axis_tready);
    predicted = median_advance(smp);
    expected_medians.push_back(known ? typed : predicted);
    samples_sent++;
    if (predicted.dropped) drops_sent++;
    @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : result_check
    median_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_medians.size() == 0) begin
        flag_mismatch("result transfer with no sample pending");
      end else begin
        want = expected_medians.pop_front();
        if (m_axis_tdata[32:0] !== want.med2)
          flag_mismatch($sformatf("median_times_two got %h want %h", m_axis_tdata[32:0],
                                  want.med2));
        if (m_axis_tdata[43:33] !== want.count)
          flag_mismatch($sformatf("sample_count got %0d want %0d", m_axis_tdata[43:33],
                                  want.count));
        if (m_axis_tuser !== want.dropped)
          flag_mismatch($sformatf("dropped got %b want %b", m_axis_tuser, want.dropped));
        if (m_axis_tdata[47:44] !== 4'h0)
          flag_mismatch($sformatf("tdata padding got %h", m_axis_tdata[47:44]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", expected_medians.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [31:0] smp;
    longint      near;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumOpening; i++) begin
      send_sample(opening_rows[i].sample, opening_rows[i].known, opening_rows[i].res);
    end

    // fill the stores to capacity, then keep pushing so samples get dropped
    while (lower_q.size() + upper_q.size() < Capacity || drops_sent < DropTail) begin
      if (samples_sent == PhaseLen) begin
        tx_idle_pct = 80;
        rx_idle_pct = 7;
      end else if (samples_sent == 2 * PhaseLen) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(0, 19)) inside
        [0:7]: smp = $urandom();
        [8:12]: smp = 32'($urandom_range(0, 40)) - 32'd20;
        [13:15]: smp = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
        default: begin
          // land on or next to the lower top to hit ties and exchanges
          near = (lower_q.size() != 0) ? lower_q[$] : 0;
          smp  = near[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
        end
      endcase
      send_sample(smp, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Pushed %0d samples through all idle patterns, %0d of them past full capacity",
             samples_sent, drops_sent);
    $display("Checked %0d median results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rmth_pkg.sv
hw/rtl/rmth_cell.sv
hw/rtl/rmth_chain.sv
hw/rtl/running_median_two_heaps.sv
tb/sv/running_median_two_heaps_tb.sv
